>>> rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII unit.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned CharW    = 6;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CntW     = $clog2(MaxDigits + 1);
  localparam int unsigned ProdW    = 2 * ValueW;

  // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [ValueW-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP_SHIFT = 35;
  localparam int unsigned       QuotW       = ProdW - RECIP_SHIFT;

  localparam logic [CharW-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CharW-1:0] CHAR_ZERO  = 6'd48;

  typedef logic [CharW-1:0]  char_t;
  typedef logic [DigitW-1:0] digit_t;
  typedef logic [CntW-1:0]   cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit_sign;
    logic emit_digit;
  } sitda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic q_zero;
    logic neg;
    logic cnt_one;
    logic out_free;
  } sitda_sts_t;

endpackage

>>> rtl/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: accept a number, divide out digits, then emit sign and digits.
// ----------------------------------------------------------------------------
module sitda_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output sitda_pkg::sitda_cmd_t cmd,
  input  sitda_pkg::sitda_sts_t sts
);
  import sitda_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.q_zero) begin
          state_nxt = ST_MUL;
        end else if (sts.neg) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free && sts.cnt_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
      end
      ST_SIGN: begin
        cmd.emit_sign = sts.out_free;
      end
      ST_EMIT: begin
        cmd.emit_digit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/sitda_dp.sv
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude, divide-by-ten step, digit stack and output register.
// ----------------------------------------------------------------------------
module sitda_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [sitda_pkg::ValueW-1:0]   in_value,
  input  sitda_pkg::sitda_cmd_t          cmd,
  output sitda_pkg::sitda_sts_t          sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sitda_pkg::CharW-1:0]    out_character,
  output logic                           out_last
);
  import sitda_pkg::*;

  logic [ValueW-1:0] mag_r;
  logic [ProdW-1:0]  prod_r;
  logic              neg_r;
  cnt_t              cnt_r;
  digit_t            digits_r [MaxDigits];
  logic              out_valid_r;
  char_t             out_char_r;
  logic              out_last_r;

  logic [QuotW-1:0]  quot;
  logic [ValueW-1:0] quot_ext;
  logic [ValueW-1:0] quot_x10;
  logic [ValueW-1:0] rem_full;
  cnt_t              rd_idx;

  assign quot     = prod_r[ProdW-1:RECIP_SHIFT];
  assign quot_ext = {{(ValueW-QuotW){1'b0}}, quot};
  assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
  assign rem_full = mag_r - quot_x10;
  assign rd_idx   = cnt_r - cnt_t'(1);

  assign sts.q_zero   = (quot == '0);
  assign sts.neg      = neg_r;
  assign sts.cnt_one  = (cnt_r == cnt_t'(1));
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_value[ValueW-1];
      mag_r <= in_value[ValueW-1] ? (~in_value + 1'b1) : in_value;
    end else if (cmd.div) begin
      mag_r <= quot_ext;
    end
    if (cmd.mul) begin
      prod_r <= ProdW'(mag_r) * ProdW'(RECIP10);
    end
    if (cmd.div) begin
      digits_r[rd_idx + cnt_t'(1)] <= rem_full[DigitW-1:0];
    end
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= CHAR_ZERO + char_t'(digits_r[rd_idx]);
      out_last_r <= (cnt_r == cnt_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.div) begin
        cnt_r <= cnt_r + cnt_t'(1);
      end else if (cmd.emit_digit) begin
        cnt_r <= rd_idx;
      end
      if (cmd.emit_sign || cmd.emit_digit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

>>> rtl/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed 32-bit integer to its decimal ASCII text, one beat per
// character, sign first, most significant digit next, last flag on the end.
// ----------------------------------------------------------------------------
//   channel | ports                          | direction
//   in      | in_valid, in_stall, in_value   | number in
//   out     | out_valid, out_stall,          | one character per beat
//           | out_character, out_last        |
//
// One number passes the accept state, then a divide-by-ten step per digit
// (reciprocal multiply, then remainder), then one emit per character; a new
// number is taken only after the last character has been emitted.
// Reset clears the sequencer and the output valid; no clearing pass.
// A stall on a valid output holds the character register and the sequencer's sign and emit states.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sitda_pkg::ValueW-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sitda_pkg::CharW-1:0]  out_character,
  output logic                         out_last
);
  import sitda_pkg::*;

  sitda_cmd_t cmd;
  sitda_sts_t sts;

  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  sitda_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
